// ----- hdl/cphe_pkg.sv -----
// Package for the code point hex escaper: fixed widths, limits and character helpers.
// Depends on nothing; used by code_point_hex_escaper_core.
`default_nettype none

package cphe_pkg;

   localparam int unsigned CodeWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned NibbleCount = CodeWidth / 4;
   localparam logic [2:0] MaxPrefix = 3'd4;
   localparam logic [2:0] PrefixHold = 3'd4;

   localparam logic [1:0] CsrPrefixLength = 2'd0;
   localparam logic [1:0] CsrPrefixBytes = 2'd1;
   localparam logic [1:0] CsrSuffixChar = 2'd2;
   localparam logic [1:0] CsrWhitelist = 2'd3;

   typedef logic [ByteWidth-1:0] byte_type;

   function automatic byte_type hex_char(input logic [3:0] nib);
      byte_type c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h57 + {4'h0, nib};
      end
      return c;
   endfunction

   function automatic logic is_alnum(input byte_type c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_listed(input byte_type c);
      logic hit;
      unique case (c)
         8'h20, 8'h2F, 8'h2A, 8'h2B, 8'h2D, 8'h09, 8'h0A, 8'h5E, 8'h24,
         8'h21, 8'h3F, 8'h5C, 8'h23, 8'h7D, 8'h7B, 8'h29, 8'h28, 8'h5D,
         8'h5B, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h5F, 8'h7C, 8'h7E, 8'h60: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/code_point_hex_escaper_core.sv -----
// Top level of the code point hex escaper: sequencer, nibble shift register and output register.
// Depends on cphe_pkg.
`default_nettype none

// Each accepted word carries one 32-bit code point. Letters, digits and (with the whitelist
// on) listed punctuation and whitespace leave as one byte; a zero code point leaves as one
// error byte and the rest of its string is dropped. Other values leave as the prefix, the
// lowercase hex digits without leading zeros, and the suffix if it is nonzero. An item is
// accepted only in the idle state. An escaped code point leaves through a nibble shift
// register that steps one nibble per cycle while the output register is free, leading zero
// nibbles included. A dropped item leaves no byte. The next item is accepted while the
// last byte still waits.
module code_point_hex_escaper_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // code_unit[31:0]
   input  wire logic        req_tlast,   // last_unit
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output cphe_pkg::byte_type rsp_tdata, // out_byte[7:0]
   output logic             rsp_tlast,   // last_of_string
   output logic [1:0]       rsp_tuser,   // error_flag, last_of_item
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import cphe_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SINGLE = 3'd1;
   localparam logic [2:0] S_PREFIX = 3'd2;
   localparam logic [2:0] S_DIGIT  = 3'd3;
   localparam logic [2:0] S_SUFFIX = 3'd4;

   logic [2:0]  prefix_length_ff;
   logic [31:0] prefix_bytes_ff;
   byte_type    suffix_char_ff;
   logic        whitelist_ff;

   logic [2:0]  state_ff, state_in;
   logic        poison_ff, poison_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic [31:0] pre_ff, pre_in;
   logic [2:0]  plen_ff, plen_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        started_ff, started_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;

   logic        out_valid_ff, out_valid_in;
   byte_type    out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic [1:0]  out_user_ff, out_user_in;

   logic        out_free;
   logic        accept;
   logic        emit;
   byte_type    emit_byte;
   logic        emit_item_last;
   logic        emit_err;
   logic [2:0]  plen_sat;
   logic [3:0]  nib;
   logic        last_digit;
   logic        pass;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_length_ff <= 3'd1;
         prefix_bytes_ff  <= 32'd92;
         suffix_char_ff   <= 8'd32;
         whitelist_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrPrefixLength: prefix_length_ff <= csr_wdata[2:0];
            CsrPrefixBytes:  prefix_bytes_ff  <= csr_wdata;
            CsrSuffixChar:   suffix_char_ff   <= csr_wdata[7:0];
            CsrWhitelist:    whitelist_ff     <= csr_wdata[0];
         endcase
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      plen_sat = prefix_length_ff;
      if (plen_sat > MaxPrefix) begin
         plen_sat = MaxPrefix;
      end
      if (plen_sat > PrefixHold) begin
         plen_sat = PrefixHold;
      end
   end

   assign pass = (req_tdata[31:8] == 24'd0) &&
                 (is_alnum(req_tdata[7:0]) || (whitelist_ff && is_listed(req_tdata[7:0])));
   assign nib        = code_ff[CodeWidth-1 -: 4];
   assign last_digit = (cnt_ff == 3'(NibbleCount - 1));

   always_comb begin
      state_in       = state_ff;
      poison_in      = poison_ff;
      code_in        = code_ff;
      pre_in         = pre_ff;
      plen_in        = plen_ff;
      cnt_in         = cnt_ff;
      started_in     = started_ff;
      last_in        = last_ff;
      err_in         = err_ff;
      emit           = 1'b0;
      emit_byte      = 8'd0;
      emit_item_last = 1'b0;
      emit_err       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               code_in    = req_tdata;
               last_in    = req_tlast;
               pre_in     = prefix_bytes_ff;
               plen_in    = plen_sat;
               cnt_in     = 3'd0;
               started_in = 1'b0;
               err_in     = 1'b0;
               if (poison_ff) begin
                  if (req_tlast) begin
                     poison_in = 1'b0;
                  end
               end else if (req_tdata == 32'd0) begin
                  err_in    = 1'b1;
                  poison_in = !req_tlast;
                  state_in  = S_SINGLE;
               end else if (pass) begin
                  state_in = S_SINGLE;
               end else if (plen_sat != 3'd0) begin
                  state_in = S_PREFIX;
               end else begin
                  state_in = S_DIGIT;
               end
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_byte      = code_ff[7:0];
               emit_item_last = 1'b1;
               emit_err       = err_ff;
               state_in       = S_IDLE;
            end
         end
         S_PREFIX: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = pre_ff[7:0];
               pre_in    = {8'd0, pre_ff[31:8]};
               cnt_in    = cnt_ff + 3'd1;
               if (cnt_ff == plen_ff - 3'd1) begin
                  cnt_in   = 3'd0;
                  state_in = S_DIGIT;
               end
            end
         end
         S_DIGIT: begin
            if (out_free) begin
               emit           = (nib != 4'd0) || started_ff || last_digit;
               emit_byte      = hex_char(nib);
               emit_item_last = last_digit && (suffix_char_ff == 8'd0);
               started_in     = started_ff || (nib != 4'd0);
               code_in        = {code_ff[CodeWidth-5:0], 4'd0};
               cnt_in         = cnt_ff + 3'd1;
               if (last_digit) begin
                  state_in = (suffix_char_ff != 8'd0) ? S_SUFFIX : S_IDLE;
               end
            end
         end
         S_SUFFIX: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_byte      = suffix_char_ff;
               emit_item_last = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_item_last && (last_ff || emit_err);
         out_user_in  = {emit_err, emit_item_last};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         poison_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poison_ff    <= poison_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      pre_ff      <= pre_in;
      plen_ff     <= plen_in;
      cnt_ff      <= cnt_in;
      started_ff  <= started_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

// ----- sim/code_point_hex_escaper_core_tb.sv -----
// Self-checking testbench for code_point_hex_escaper_core: streams code points through the
// escaper under several register settings, with random stalls on both sides.
// Depends on cphe_pkg and code_point_hex_escaper_core; a scoreboard class predicts each byte.
`timescale 1ns / 100ps

module code_point_hex_escaper_core_tb;
   import cphe_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int LongHold = 300;
   localparam int SettleCycles = 20;
   localparam string Punct = " /*+-\t\n^$!?\\#{}()[].,:;_|~\140";

   typedef struct packed {
      logic [7:0] ch;
      logic item_end;
      logic string_end;
      logic err;
   } esc_byte_type;

   class escape_scoreboard_type;
      logic [2:0] plen_reg;
      logic [31:0] prefix_reg;
      logic [7:0] suffix_reg;
      logic wl_reg;
      logic poisoned;
      esc_byte_type expected_q[$];
      int failures;

      function new();
         plen_reg = 3'd1;
         prefix_reg = 32'd92;
         suffix_reg = 8'd32;
         wl_reg = 1'b0;
         poisoned = 1'b0;
         failures = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CsrPrefixLength: plen_reg = val[2:0];
            CsrPrefixBytes: prefix_reg = val;
            CsrSuffixChar: suffix_reg = val[7:0];
            CsrWhitelist: wl_reg = val[0];
            default: ;
         endcase
      endfunction

      function bit passes_plain(logic [31:0] c);
         int i;
         if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            return 1'b1;
         end
         if (!wl_reg) begin
            return 1'b0;
         end
         for (i = 0; i < Punct.len(); i++) begin
            if (c == 32'(Punct[i])) begin
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function logic [7:0] hex_glyph(logic [3:0] n);
         return (n < 4'd10) ? 8'd48 + 8'(n) : 8'd97 + 8'(n) - 8'd10;
      endfunction

      function void note_word(logic [31:0] code, logic last);
         esc_byte_type seq[$];
         esc_byte_type b;
         int plen;
         int digits;
         int i;
         if (poisoned) begin
            if (last) begin
               poisoned = 1'b0;
            end
            return;
         end
         if (code == 32'd0) begin
            expected_q.push_back('{ch: 8'h00, item_end: 1'b1, string_end: 1'b1, err: 1'b1});
            if (!last) begin
               poisoned = 1'b1;
            end
            return;
         end
         if (passes_plain(code)) begin
            expected_q.push_back('{ch: code[7:0], item_end: 1'b1, string_end: last, err: 1'b0});
            return;
         end
         plen = (plen_reg > MaxPrefix) ? int'(MaxPrefix) : int'(plen_reg);
         if (plen > 4) begin
            plen = 4;
         end
         digits = 1;
         for (i = 1; i < 8; i++) begin
            if ((code >> (4 * i)) != 32'd0) begin
               digits = i + 1;
            end
         end
         for (i = 0; i < plen; i++) begin
            seq.push_back('{ch: prefix_reg[8*i +: 8], item_end: 1'b0, string_end: 1'b0,
                            err: 1'b0});
         end
         for (i = digits - 1; i >= 0; i--) begin
            seq.push_back('{ch: hex_glyph(code[4*i +: 4]), item_end: 1'b0, string_end: 1'b0,
                            err: 1'b0});
         end
         if (suffix_reg != 8'd0) begin
            seq.push_back('{ch: suffix_reg, item_end: 1'b0, string_end: 1'b0, err: 1'b0});
         end
         b = seq[seq.size() - 1];
         b.item_end = 1'b1;
         b.string_end = last;
         seq[seq.size() - 1] = b;
         foreach (seq[i]) begin
            expected_q.push_back(seq[i]);
         end
      endfunction

      function void check_byte(esc_byte_type got);
         esc_byte_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected output word: out_byte %h", got.ch);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.ch !== want.ch) begin
            $error("out_byte: expected %h, actual %h", want.ch, got.ch);
            failures++;
         end
         if (got.item_end !== want.item_end) begin
            $error("last_of_item: expected %b, actual %b", want.item_end, got.item_end);
            failures++;
         end
         if (got.string_end !== want.string_end) begin
            $error("last_of_string: expected %b, actual %b", want.string_end, got.string_end);
            failures++;
         end
         if (got.err !== want.err) begin
            $error("error_flag: expected %b, actual %b", want.err, got.err);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   byte_type rsp_tdata;
   logic rsp_tlast;
   logic [1:0] rsp_tuser;
   logic csr_we;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;

   escape_scoreboard_type sb;
   bit quiet;
   bit hold_rsp;
   int idle_cycles;

   code_point_hex_escaper_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_byte('{ch: rsp_tdata, item_end: rsp_tuser[0], string_end: rsp_tlast,
                            err: rsp_tuser[1]});
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [31:0] code, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic program_regs(input logic [2:0] plen, input logic [31:0] pbytes,
                               input logic [7:0] suffix, input logic wl);
      write_csr(CsrPrefixLength, {29'd0, plen});
      write_csr(CsrPrefixBytes, pbytes);
      write_csr(CsrSuffixChar, {24'd0, suffix});
      write_csr(CsrWhitelist, {31'd0, wl});
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         return 32'($urandom_range(1, 127));
      end else if (sel < 40) begin
         return 32'(Punct[$urandom_range(0, Punct.len() - 1)]);
      end else if (sel < 48) begin
         return 32'd0;
      end else if (sel < 55) begin
         return ($urandom << 8) | 32'($urandom_range(0, 127));
      end
      return $urandom >> $urandom_range(0, 31);
   endfunction

   task automatic run_random(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         send_word(pick_code(), 1'($urandom_range(0, 4) == 0));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 32'd0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CsrPrefixLength;
      csr_wdata = 32'd0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      idle_cycles = 0;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: boundaries of the letter and digit ranges, hex widths, and a
      // zero code point that discards the rest of its string.
      send_word(32'h30, 1'b0);
      send_word(32'h39, 1'b0);
      send_word(32'h41, 1'b0);
      send_word(32'h5A, 1'b0);
      send_word(32'h61, 1'b0);
      send_word(32'h7A, 1'b1);
      send_word(32'h2F, 1'b0);
      send_word(32'h3A, 1'b0);
      send_word(32'h40, 1'b0);
      send_word(32'h5B, 1'b0);
      send_word(32'h60, 1'b0);
      send_word(32'h7B, 1'b0);
      send_word(32'h20, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0010_FFFF, 1'b1);
      send_word(32'h0000_0141, 1'b0);
      send_word(32'h61, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h62, 1'b0);
      send_word(32'h0, 1'b0);
      send_word(32'h63, 1'b1);
      send_word(32'h0, 1'b1);
      send_word(32'h7F, 1'b1);
      run_random(42);
      drain();

      program_regs(3'd0, 32'h1122_3344, 8'h00, 1'b1);
      run_random(42);
      drain();

      // Zero bytes inside the prefix; the receiver holds off long enough to back up the input.
      program_regs(3'd4, 32'h005C_0026, 8'hFF, 1'b0);
      hold_rsp = 1'b1;
      run_random(42);
      drain();

      // A prefix length beyond the limit saturates.
      program_regs(3'd7, 32'hFFFF_FFFF, 8'h3B, 1'b1);
      run_random(42);
      drain();

      program_regs(3'd2, $urandom, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
      run_random(42);
      drain();

      program_regs(3'd3, $urandom, 8'h80, 1'b1);
      quiet = 1'b1;
      run_random(42);
      drain();

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/cphe_pkg.sv
hdl/code_point_hex_escaper_core.sv
sim/code_point_hex_escaper_core_tb.sv
